[hw/rtl/locs_pkg.sv]
package locs_pkg;

  localparam int TREE_DEPTH = 4;

  // Scaled datapath width: coordinates carry TREE_DEPTH extra fraction bits
  localparam int SW = 27 + TREE_DEPTH;
  localparam int LVL_W = $clog2(TREE_DEPTH) + 2;
  localparam int PATH_W = (3 * TREE_DEPTH > 9) ? 3 * TREE_DEPTH : 9;
  localparam int LATENCY = TREE_DEPTH + 1;

  localparam int REG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_ROOT_CENTER_X = 3'd0;
  localparam reg_idx_t REG_ROOT_CENTER_Y = 3'd1;
  localparam reg_idx_t REG_ROOT_CENTER_Z = 3'd2;
  localparam reg_idx_t REG_ROOT_HALF_SIZE = 3'd3;
  localparam reg_idx_t REG_QUAD_MODE = 3'd4;

  typedef logic signed [SW-1:0] fix_t;

  typedef struct packed {
    logic              active;
    logic              found;
    logic [LVL_W-1:0]  level;
    logic [PATH_W-1:0] path;
    fix_t              sx;
    fix_t              sy;
    fix_t              sz;
    fix_t              r;
    fix_t              cx;
    fix_t              cy;
    fix_t              cz;
  } node_t;

  function automatic logic axis_in(fix_t s, fix_t r, fix_t c, fix_t lim);
    return ((s + r) < (c + lim)) && ((s - r) > (c - lim));
  endfunction

  function automatic fix_t scale_coord(logic signed [23:0] v);
    fix_t t;
    t = SW'(v);
    return t <<< TREE_DEPTH;
  endfunction

  function automatic fix_t scale_radius(logic [22:0] v);
    fix_t t;
    t = SW'(v);
    return t <<< TREE_DEPTH;
  endfunction

endpackage

[hw/rtl/loose_octree_cell_select.sv]
// channel   direction  handshake            payload
// input     in         start, busy          sphere_x, sphere_y, sphere_z, sphere_radius
// result    out        strobe               found, node_level, node_path
// config    in         wr_en                wr_index, wr_data
//
// One beat accepted per cycle; busy is high only during reset.
// The input register loads at the accepting edge, then the root test stage and one
// stage per tree level below the root follow; the result is on the ports once the
// last level stage has registered it.
// rst clears the pipeline valid bits and loads register defaults.
// The receiver cannot stall; the strobe is valid for exactly one cycle.
module loose_octree_cell_select (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [23:0]                   sphere_x,
  input  logic signed [23:0]                   sphere_y,
  input  logic signed [23:0]                   sphere_z,
  input  logic [22:0]                          sphere_radius,
  input  logic                                 wr_en,
  input  logic [locs_pkg::REG_IDX_W-1:0]       wr_index,
  input  logic [locs_pkg::CFG_DATA_W-1:0]      wr_data,
  output logic                                 strobe,
  output logic                                 found,
  output logic [1:0]                           node_level,
  output logic [8:0]                           node_path
);
  import locs_pkg::*;

  logic signed [23:0] root_cx, root_cy, root_cz;
  logic [21:0]        root_half;
  logic               quad;

  logic               in_vld;
  logic signed [23:0] in_sx, in_sy, in_sz;
  logic [22:0]        in_r;

  logic  vld [TREE_DEPTH];
  node_t nd [TREE_DEPTH];
  node_t root_next;

  fix_t hf, h3, root_lim;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_cx <= '0;
      root_cy <= '0;
      root_cz <= '0;
      root_half <= 22'd4096;
      quad <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ROOT_CENTER_X:  root_cx <= wr_data;
        REG_ROOT_CENTER_Y:  root_cy <= wr_data;
        REG_ROOT_CENTER_Z:  root_cz <= wr_data;
        REG_ROOT_HALF_SIZE: root_half <= wr_data[21:0];
        REG_QUAD_MODE:      quad <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start;
    end
    in_sx <= sphere_x;
    in_sy <= sphere_y;
    in_sz <= sphere_z;
    in_r <= sphere_radius;
  end

  assign hf = SW'(root_half);
  assign h3 = (hf <<< 1) + hf;
  assign root_lim = h3 <<< (TREE_DEPTH - 1);

  always_comb begin
    root_next.sx = scale_coord(in_sx);
    root_next.sy = scale_coord(in_sy);
    root_next.sz = scale_coord(in_sz);
    root_next.r = scale_radius(in_r);
    root_next.cx = scale_coord(root_cx);
    root_next.cy = scale_coord(root_cy);
    root_next.cz = scale_coord(root_cz);
    root_next.level = '0;
    root_next.path = '0;
    root_next.found = axis_in(root_next.sx, root_next.r, root_next.cx, root_lim) &&
                      (quad || axis_in(root_next.sy, root_next.r, root_next.cy, root_lim)) &&
                      axis_in(root_next.sz, root_next.r, root_next.cz, root_lim);
    root_next.active = root_next.found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
    nd[0] <= root_next;
  end

  for (genvar k = 1; k < TREE_DEPTH; k++) begin : g_level
    fix_t  off;
    fix_t  lim;
    node_t step_next;

    assign off = hf <<< (TREE_DEPTH - k);
    assign lim = h3 <<< (TREE_DEPTH - k - 1);

    locs_step u_step (
      .prev (nd[k-1]),
      .off  (off),
      .lim  (lim),
      .quad (quad),
      .next (step_next)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      nd[k] <= step_next;
    end
  end

  assign strobe = vld[TREE_DEPTH-1];
  assign found = nd[TREE_DEPTH-1].found;
  assign node_level = nd[TREE_DEPTH-1].level[1:0];
  assign node_path = nd[TREE_DEPTH-1].path[8:0];

endmodule

[hw/rtl/locs_step.sv]
module locs_step (
  input  locs_pkg::node_t prev,
  input  locs_pkg::fix_t  off,
  input  locs_pkg::fix_t  lim,
  input  logic            quad,
  output locs_pkg::node_t next
);
  import locs_pkg::*;

  logic x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
  logic xp, yp, zp;
  logic x_ok, y_ok, z_ok;
  logic take;
  logic [2:0] code;

  always_comb begin
    x_lo = axis_in(prev.sx, prev.r, prev.cx - off, lim);
    x_hi = axis_in(prev.sx, prev.r, prev.cx + off, lim);
    y_lo = axis_in(prev.sy, prev.r, prev.cy - off, lim);
    y_hi = axis_in(prev.sy, prev.r, prev.cy + off, lim);
    z_lo = axis_in(prev.sz, prev.r, prev.cz - off, lim);
    z_hi = axis_in(prev.sz, prev.r, prev.cz + off, lim);

    // first enclosing child in code order: low side wins per axis
    xp = !x_lo;
    yp = quad ? 1'b0 : !y_lo;
    zp = !z_lo;
    x_ok = x_lo || x_hi;
    y_ok = quad || y_lo || y_hi;
    z_ok = z_lo || z_hi;
    take = prev.active && x_ok && y_ok && z_ok;
    code = quad ? {1'b0, xp, zp} : {xp, yp, zp};

    next = prev;
    if (take) begin
      next.level = prev.level + LVL_W'(1);
      next.path = prev.path | (PATH_W'(code) << (3 * prev.level));
      next.cx = xp ? prev.cx + off : prev.cx - off;
      next.cz = zp ? prev.cz + off : prev.cz - off;
      if (!quad) begin
        next.cy = yp ? prev.cy + off : prev.cy - off;
      end
    end else begin
      next.active = 1'b0;
    end
  end

endmodule

[hw/rtl/locs_checker.sv]
module locs_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic       found,
  input logic [1:0] node_level,
  input logic [8:0] node_path
);
  import locs_pkg::*;

  // every accepted beat yields a result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY strobe)
    else $error("accepted beat produced no result");

  // no result without a matching accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, LATENCY))
    else $error("result without accepted beat");

  // a miss at the root reports level and path as zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && !found) |-> (node_level == 2'd0 && node_path == 9'd0))
    else $error("miss carries nonzero level or path");

  // busy only while in reset
  a_busy_reset: assert property (@(posedge clk)
    busy |-> rst)
    else $error("busy outside reset");

endmodule

bind loose_octree_cell_select locs_checker u_locs_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .found      (found),
  .node_level (node_level),
  .node_path  (node_path)
);
